// ----- hdl/ssbm_pkg.sv -----
// Shared types, request codes and controller/datapath interface structs
// for the sparse SDDMM backward merge block. No dependencies.
package ssbm_pkg;

    localparam int ROWS_MAX_DEF = 64;
    localparam int NNZ_MAX_DEF  = 1024;

    localparam logic [3:0] REQ_L_RPTR = 4'd0;
    localparam logic [3:0] REQ_L_ENT  = 4'd1;
    localparam logic [3:0] REQ_M_RPTR = 4'd2;
    localparam logic [3:0] REQ_M_ENT  = 4'd3;
    localparam logic [3:0] REQ_T_RPTR = 4'd4;
    localparam logic [3:0] REQ_T_ENT  = 4'd5;
    localparam logic [3:0] REQ_RUN    = 4'd6;
    localparam logic [3:0] REQ_RD_DL  = 4'd7;
    localparam logic [3:0] REQ_RD_DM  = 4'd8;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [9:0]         index;
        logic [10:0]        row_start;
        logic [9:0]         column;
        logic signed [15:0] value;
    } req_t;

    typedef struct packed {
        logic signed [39:0] grad_value;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic row_rd_hi;
        logic row_latch;
        logic row_next;
        logic t_latch;
        logic t_next;
        logic m_rd_hi;
        logic m_latch;
        logic e_cmp;
        logic e_acc;
        logic rsp_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic row_last;
        logic t_done;
        logic q_bad;
        logic merge_done;
        logic cols_equal;
    } status_t;

endpackage

// ----- hdl/ssbm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ssbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/ssbm_ctrl.sv -----
// Sequencing state machine for request handling, clearing and the merge walk.
// Depends on ssbm_pkg for request codes and the command/status structs.
module ssbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [3:0]         req_type,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  ssbm_pkg::status_t  status,
    output ssbm_pkg::cmd_t     cmd
);
    import ssbm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_ROW  = 4'd2;
    localparam logic [3:0] S_R1   = 4'd3;
    localparam logic [3:0] S_R2   = 4'd4;
    localparam logic [3:0] S_T0   = 4'd5;
    localparam logic [3:0] S_T1   = 4'd6;
    localparam logic [3:0] S_T2   = 4'd7;
    localparam logic [3:0] S_T3   = 4'd8;
    localparam logic [3:0] S_T4   = 4'd9;
    localparam logic [3:0] S_M0   = 4'd10;
    localparam logic [3:0] S_M1   = 4'd11;
    localparam logic [3:0] S_M2   = 4'd12;
    localparam logic [3:0] S_RD   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       run_reg, run_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       is_read;
    logic       take;

    assign is_read = (req_type == REQ_RD_DL) || (req_type == REQ_RD_DM);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        run_next   = run_reg;
        req_stall  = 1'b1;
        take       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                // a read needs the response register free by the time data returns
                req_stall = is_read && rsp_valid_reg && rsp_stall;
                take      = req_valid && !(is_read && rsp_valid_reg && rsp_stall);
                if (take)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == REQ_RUN)
                    begin
                        state_next = S_CLR;
                        run_next   = 1'b1;
                    end
                    else if (is_read)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = run_reg ? S_ROW : S_IDLE;
                end
            end
            S_ROW:
            begin
                if (status.row_last)
                begin
                    state_next = S_IDLE;
                    run_next   = 1'b0;
                end
                else
                begin
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                cmd.row_rd_hi = 1'b1;
                state_next    = S_R2;
            end
            S_R2:
            begin
                cmd.row_latch = 1'b1;
                state_next    = S_T0;
            end
            S_T0:
            begin
                if (status.t_done)
                begin
                    cmd.row_next = 1'b1;
                    state_next   = S_ROW;
                end
                else
                begin
                    state_next = S_T1;
                end
            end
            S_T1:
            begin
                cmd.t_latch = 1'b1;
                state_next  = S_T2;
            end
            S_T2:
            begin
                if (status.q_bad)
                begin
                    cmd.t_next = 1'b1;
                    state_next = S_T0;
                end
                else
                begin
                    state_next = S_T3;
                end
            end
            S_T3:
            begin
                cmd.m_rd_hi = 1'b1;
                state_next  = S_T4;
            end
            S_T4:
            begin
                cmd.m_latch = 1'b1;
                state_next  = S_M0;
            end
            S_M0:
            begin
                if (status.merge_done)
                begin
                    cmd.t_next = 1'b1;
                    state_next = S_T0;
                end
                else
                begin
                    state_next = S_M1;
                end
            end
            S_M1:
            begin
                cmd.e_cmp  = 1'b1;
                state_next = status.cols_equal ? S_M2 : S_M0;
            end
            S_M2:
            begin
                cmd.e_acc  = 1'b1;
                state_next = S_M0;
            end
            S_RD:
            begin
                cmd.rsp_load = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = cmd.rsp_load ? 1'b1 : (rsp_valid_reg && rsp_stall);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            run_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hdl/ssbm_dp.sv -----
// Datapath: CSR stores, accumulator memories, walk counters, multiply and
// saturating accumulate. Depends on ssbm_pkg and ssbm_ram.
module ssbm_dp #(
    parameter int ROWS_MAX = ssbm_pkg::ROWS_MAX_DEF,
    parameter int NNZ_MAX  = ssbm_pkg::NNZ_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ssbm_pkg::req_t     req,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data,
    input  ssbm_pkg::cmd_t     cmd,
    output ssbm_pkg::status_t  status,
    output ssbm_pkg::rsp_t     rsp
);
    import ssbm_pkg::*;

    localparam int RAW = $clog2(ROWS_MAX + 1);
    localparam int AW  = $clog2(NNZ_MAX);
    localparam int PW  = $clog2(NNZ_MAX + 1);

    function automatic logic [PW-1:0] clamp_ptr(input logic [10:0] v);
        if (17'(v) > 17'(NNZ_MAX))
        begin
            return PW'(NNZ_MAX);
        end
        return PW'(v);
    endfunction

    logic [6:0]          row_count_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [RAW-1:0]      p_reg;
    logic [PW-1:0]       t_reg, t_hi_reg, l_lo_reg, l_hi_reg;
    logic [PW-1:0]       m_lo_reg, m_hi_reg, li_reg, mi_reg;
    logic [5:0]          q_reg;
    logic signed [15:0]  g_reg;
    logic signed [31:0]  prod_l_reg, prod_m_reg;
    logic                sat_reg;
    logic                rd_ok_reg, rd_dm_reg;
    rsp_t                rsp_reg;

    logic                row_ok, ent_ok, is_run;
    logic [RAW-1:0]      ridx;
    logic [AW-1:0]       eidx, li_a, mi_a, t_a;
    logic [10:0]         rows_eff;
    logic [RAW-1:0]      rp_raddr, mrp_raddr, q_r;

    logic [10:0]         lrp_rd, mrp_rd, trp_rd;
    logic [25:0]         lent_rd, ment_rd;
    logic [21:0]         tent_rd;
    logic [39:0]         dl_rd, dm_rd;

    logic                acc_we;
    logic [AW-1:0]       acc_waddr, dl_raddr, dm_raddr;
    logic [39:0]         dl_wdata, dm_wdata;
    logic [40:0]         sum_l, sum_m;
    logic [39:0]         sat_l, sat_m;
    logic                ovf_l, ovf_m;

    assign row_ok = 11'(req.index) <= 11'(ROWS_MAX);
    assign ent_ok = 17'(req.index) < 17'(NNZ_MAX);
    assign is_run = cmd.accept && (req.req_type == REQ_RUN);
    assign ridx   = RAW'(req.index);
    assign eidx   = AW'(req.index);
    assign li_a   = AW'(li_reg);
    assign mi_a   = AW'(mi_reg);
    assign t_a    = AW'(t_reg);
    assign q_r    = RAW'(q_reg);

    assign rows_eff  = (11'(row_count_reg) > 11'(ROWS_MAX)) ? 11'(ROWS_MAX)
                                                             : 11'(row_count_reg);
    assign rp_raddr  = cmd.row_rd_hi ? (p_reg + RAW'(1)) : p_reg;
    assign mrp_raddr = cmd.m_rd_hi ? (q_r + RAW'(1)) : q_r;

    ssbm_ram #(.WIDTH(11), .DEPTH(ROWS_MAX + 1)) u_lrp (
        .clk(clk), .we(cmd.accept && req.req_type == REQ_L_RPTR && row_ok),
        .waddr(ridx), .wdata(req.row_start), .raddr(rp_raddr), .rdata(lrp_rd));
    ssbm_ram #(.WIDTH(11), .DEPTH(ROWS_MAX + 1)) u_mrp (
        .clk(clk), .we(cmd.accept && req.req_type == REQ_M_RPTR && row_ok),
        .waddr(ridx), .wdata(req.row_start), .raddr(mrp_raddr), .rdata(mrp_rd));
    ssbm_ram #(.WIDTH(11), .DEPTH(ROWS_MAX + 1)) u_trp (
        .clk(clk), .we(cmd.accept && req.req_type == REQ_T_RPTR && row_ok),
        .waddr(ridx), .wdata(req.row_start), .raddr(rp_raddr), .rdata(trp_rd));

    ssbm_ram #(.WIDTH(26), .DEPTH(NNZ_MAX)) u_lent (
        .clk(clk), .we(cmd.accept && req.req_type == REQ_L_ENT && ent_ok),
        .waddr(eidx), .wdata({req.column, req.value}), .raddr(li_a), .rdata(lent_rd));
    ssbm_ram #(.WIDTH(26), .DEPTH(NNZ_MAX)) u_ment (
        .clk(clk), .we(cmd.accept && req.req_type == REQ_M_ENT && ent_ok),
        .waddr(eidx), .wdata({req.column, req.value}), .raddr(mi_a), .rdata(ment_rd));
    ssbm_ram #(.WIDTH(22), .DEPTH(NNZ_MAX)) u_tent (
        .clk(clk), .we(cmd.accept && req.req_type == REQ_T_ENT && ent_ok),
        .waddr(eidx), .wdata({req.column[5:0], req.value}), .raddr(t_a),
        .rdata(tent_rd));

    // saturating accumulate on the registered products
    assign sum_l = {dl_rd[39], dl_rd} + {{9{prod_l_reg[31]}}, prod_l_reg};
    assign sum_m = {dm_rd[39], dm_rd} + {{9{prod_m_reg[31]}}, prod_m_reg};
    assign ovf_l = sum_l[40] != sum_l[39];
    assign ovf_m = sum_m[40] != sum_m[39];
    assign sat_l = ovf_l ? {sum_l[40], {39{~sum_l[40]}}} : sum_l[39:0];
    assign sat_m = ovf_m ? {sum_m[40], {39{~sum_m[40]}}} : sum_m[39:0];

    assign acc_we    = cmd.clr_step || cmd.e_acc;
    assign acc_waddr = cmd.clr_step ? clr_cnt_reg : li_a;
    assign dl_wdata  = cmd.clr_step ? 40'd0 : sat_l;
    assign dm_wdata  = cmd.clr_step ? 40'd0 : sat_m;
    assign dl_raddr  = cmd.accept ? eidx : li_a;
    assign dm_raddr  = cmd.accept ? eidx : mi_a;

    ssbm_ram #(.WIDTH(40), .DEPTH(NNZ_MAX)) u_dl (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(dl_wdata),
        .raddr(dl_raddr), .rdata(dl_rd));
    ssbm_ram #(.WIDTH(40), .DEPTH(NNZ_MAX)) u_dm (
        .clk(clk), .we(acc_we), .waddr(cmd.clr_step ? clr_cnt_reg : mi_a),
        .wdata(dm_wdata), .raddr(dm_raddr), .rdata(dm_rd));

    assign status.clr_last   = clr_cnt_reg == AW'(NNZ_MAX - 1);
    assign status.row_last   = 11'(p_reg) >= rows_eff;
    assign status.t_done     = t_reg >= t_hi_reg;
    assign status.q_bad      = 11'(q_reg) >= 11'(ROWS_MAX);
    assign status.merge_done = !((li_reg < l_hi_reg) && (mi_reg < m_hi_reg));
    assign status.cols_equal = lent_rd[25:16] == ment_rd[25:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            clr_cnt_reg   <= '0;
            p_reg         <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_count_reg <= cfg_data;
            end
            if (is_run)
            begin
                clr_cnt_reg <= '0;
                p_reg       <= '0;
                sat_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.clr_step)
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                if (cmd.row_next)
                begin
                    p_reg <= p_reg + RAW'(1);
                end
                if (cmd.e_acc && (ovf_l || ovf_m))
                begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_rd_hi)
        begin
            l_lo_reg <= clamp_ptr(lrp_rd);
            t_reg    <= clamp_ptr(trp_rd);
        end
        if (cmd.row_latch)
        begin
            l_hi_reg <= clamp_ptr(lrp_rd);
            t_hi_reg <= clamp_ptr(trp_rd);
        end
        if (cmd.t_next)
        begin
            t_reg <= t_reg + PW'(1);
        end
        if (cmd.t_latch)
        begin
            q_reg <= tent_rd[21:16];
            g_reg <= $signed(tent_rd[15:0]);
        end
        if (cmd.m_rd_hi)
        begin
            m_lo_reg <= clamp_ptr(mrp_rd);
        end
        if (cmd.m_latch)
        begin
            m_hi_reg <= clamp_ptr(mrp_rd);
            li_reg   <= l_lo_reg;
            mi_reg   <= m_lo_reg;
        end
        if (cmd.e_cmp)
        begin
            prod_l_reg <= g_reg * $signed(ment_rd[15:0]);
            prod_m_reg <= g_reg * $signed(lent_rd[15:0]);
            if (!status.cols_equal)
            begin
                if (lent_rd[25:16] < ment_rd[25:16])
                begin
                    li_reg <= li_reg + PW'(1);
                end
                else
                begin
                    mi_reg <= mi_reg + PW'(1);
                end
            end
        end
        if (cmd.e_acc)
        begin
            li_reg <= li_reg + PW'(1);
            mi_reg <= mi_reg + PW'(1);
        end
        if (cmd.accept)
        begin
            rd_ok_reg <= ent_ok;
            rd_dm_reg <= req.req_type == REQ_RD_DM;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.grad_value <= rd_ok_reg ? $signed(rd_dm_reg ? dm_rd : dl_rd) : '0;
            rsp_reg.saturated  <= sat_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- hdl/sparse_sddmm_backward_merge.sv -----
// Load items complete on acceptance; a read item goes through S_RD, which loads the
// response register. A run item clears both accumulator memories, then walks each
// target row (S_ROW, S_R1, S_R2) and, per target entry, sets up (S_T0 to S_T4) and
// merges: each merge step compares (S_M0, S_M1), plus an accumulate (S_M2) on a column
// match. The merge rate is set by the registered-read entry memories and the
// read-modify-write of the accumulator memories. After reset the same clearing pass
// runs before the first item is accepted; config is taken.
module sparse_sddmm_backward_merge #(
    parameter int ROWS_MAX = ssbm_pkg::ROWS_MAX_DEF,
    parameter int NNZ_MAX  = ssbm_pkg::NNZ_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ssbm_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ssbm_pkg::rsp_t  rsp,
    input  logic            cfg_we,
    input  logic [6:0]      cfg_data
);
    import ssbm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Controller: owns the handshake and sequences every datapath step.
    ssbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: stores, counters, multipliers and the response register.
    ssbm_dp #(
        .ROWS_MAX (ROWS_MAX),
        .NNZ_MAX  (NNZ_MAX)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .rsp      (rsp)
    );

    // A read transfer yields a valid response, loaded from the S_RD state.
    a_read_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall &&
         (req.req_type == REQ_RD_DL || req.req_type == REQ_RD_DM)) |-> ##2 rsp_valid)
        else $error("read transfer produced no response");

    // Accumulate only directly after a matching compare.
    a_acc_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.e_acc |-> $past(cmd.e_cmp))
        else $error("accumulate without preceding compare");

    // A new response appears only after a response load.
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !$past(rsp_valid)) |-> $past(cmd.rsp_load))
        else $error("response valid without load");

endmodule
